// ===== sv/dqdel_pkg.sv =====
// Package for the double-ended queue with delete by value.
// Holds operation codes, status codes, field widths and parameter defaults.
// No dependencies.
package dqdel_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd3;

endpackage

// ===== sv/deque_with_delete_by_value.sv =====
// Bounded double-ended queue of signed words with delete of the first match.
// One circular memory, one compare unit and a small sequencer; uses dqdel_pkg.
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+---------------------------
//   request   | i_operation, i_value                    | start high, busy low
//   result    | o_read_value, o_status, o_entry_count   | o_valid, one cycle
//
// Steps: a push, an unknown code, or a pop or delete on an empty queue ends in S_DECODE;
// a pop reads its entry there and gives it from S_POP; a delete examines entries from
// the front (S_SRD, S_SCMP) and on a match moves each later entry forward (S_MRD, S_MWR);
// the single registered memory read port is read once per examined or moved entry.
// Reset (i_rst_n low, synchronous) empties the queue; the memory is not cleared.
// The receiver cannot stall: each result is shown for one cycle with o_valid.
module deque_with_delete_by_value
    import dqdel_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [OP_W-1:0]            i_operation,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       busy,
    output logic                       o_valid,
    output logic signed [VALUE_W-1:0]  o_read_value,
    output logic [STATUS_W-1:0]        o_status,
    output logic [COUNT_W-1:0]         o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_SRD,
        S_SCMP,
        S_MRD,
        S_MWR
    } t_state;

    t_state                r_state;
    logic [OP_W-1:0]       r_op;
    logic [DATA_WIDTH-1:0] r_word;
    logic [AW-1:0]         r_front;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;

    logic                  is_full;
    logic                  is_empty;
    logic [AW-1:0]         front_dec;
    logic [AW-1:0]         front_inc;
    logic [CW-1:0]         idx_next;

    // Maps a position counted from the front onto a memory address.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] front,
                                           input logic [CW-1:0] logical);
        logic [CW:0] sum;
        sum = (CW+1)'(front) + (CW+1)'(logical);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign idx_next  = r_idx + CW'(1);
    assign busy      = (r_state != S_IDLE);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot(r_front, r_count);
        mem_wdata = r_word;
        mem_raddr = slot(r_front, r_idx);
        unique case (r_state)
            S_DECODE: begin
                if (r_op == OP_PUSH_BACK) begin
                    mem_we = !is_full;
                end else if (r_op == OP_PUSH_FRONT) begin
                    mem_we    = !is_full;
                    mem_waddr = front_dec;
                end
                if (r_op == OP_POP_BACK) begin
                    mem_raddr = slot(r_front, r_count - CW'(1));
                end else begin
                    mem_raddr = r_front;
                end
            end
            S_MRD: begin
                mem_raddr = slot(r_front, idx_next);
            end
            S_MWR: begin
                mem_we    = 1'b1;
                mem_waddr = slot(r_front, r_idx);
                mem_wdata = r_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_op    <= OP_PUSH_BACK;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    o_valid <= 1'b0;
                    if (start) begin
                        r_op    <= i_operation;
                        r_word  <= DATA_WIDTH'(i_value);
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    o_read_value <= '0;
                    r_idx        <= '0;
                    unique case (r_op)
                        OP_PUSH_BACK, OP_PUSH_FRONT: begin
                            o_valid <= 1'b1;
                            r_state <= S_IDLE;
                            if (is_full) begin
                                o_status      <= ST_FULL;
                                o_entry_count <= COUNT_W'(r_count);
                            end else begin
                                o_status      <= ST_OK;
                                r_count       <= r_count + CW'(1);
                                o_entry_count <= COUNT_W'(r_count + CW'(1));
                                if (r_op == OP_PUSH_FRONT) begin
                                    r_front <= front_dec;
                                end
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT, OP_DELETE: begin
                            o_entry_count <= COUNT_W'(r_count);
                            if (is_empty) begin
                                o_status <= ST_EMPTY;
                                o_valid  <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                // The result comes from a later state.
                                o_status <= ST_OK;
                                o_valid  <= 1'b0;
                                r_state  <= (r_op == OP_DELETE) ? S_SCMP : S_POP;
                            end
                        end
                        default: begin
                            o_status      <= ST_OK;
                            o_entry_count <= COUNT_W'(r_count);
                            o_valid       <= 1'b1;
                            r_state       <= S_IDLE;
                        end
                    endcase
                end
                S_POP: begin
                    o_read_value  <= VALUE_W'($signed(r_rdata));
                    o_status      <= ST_OK;
                    o_entry_count <= COUNT_W'(r_count - CW'(1));
                    o_valid       <= 1'b1;
                    r_count       <= r_count - CW'(1);
                    if (r_op == OP_POP_FRONT) begin
                        r_front <= front_inc;
                    end
                    r_state <= S_IDLE;
                end
                S_SRD: begin
                    o_valid <= 1'b0;
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    // r_rdata holds the entry at position r_idx from the front.
                    if (r_rdata == r_word) begin
                        o_valid <= 1'b0;
                        r_state <= S_MRD;
                    end else if (idx_next == r_count) begin
                        o_read_value  <= '0;
                        o_status      <= ST_NO_MATCH;
                        o_entry_count <= COUNT_W'(r_count);
                        o_valid       <= 1'b1;
                        r_state       <= S_IDLE;
                    end else begin
                        o_valid <= 1'b0;
                        r_idx   <= idx_next;
                        r_state <= S_SRD;
                    end
                end
                S_MRD: begin
                    if (idx_next >= r_count) begin
                        o_read_value  <= '0;
                        o_status      <= ST_OK;
                        o_entry_count <= COUNT_W'(r_count - CW'(1));
                        o_valid       <= 1'b1;
                        r_count       <= r_count - CW'(1);
                        r_state       <= S_IDLE;
                    end else begin
                        o_valid <= 1'b0;
                        r_state <= S_MWR;
                    end
                end
                S_MWR: begin
                    o_valid <= 1'b0;
                    r_idx   <= idx_next;
                    r_state <= S_MRD;
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for deque_with_delete_by_value: directed and random requests,
// a queue-based predictor of the deque and an in-order compare of every result.
// Depends on dqdel_pkg and the deque RTL.
`timescale 1ns / 1ps

module tb_top;
    import dqdel_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int ITEMS_PER_RUN = 325;
    localparam int DRAIN_CYCLES  = 40;
    localparam int QUIET_LIMIT   = 1000;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        int unsigned               idle_pct;
    } deque_req_t;

    typedef struct {
        logic signed [VALUE_W-1:0] read_value;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        entry_count;
    } deque_result_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [OP_W-1:0]           i_operation = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      busy;
    logic                      o_valid;
    logic signed [VALUE_W-1:0] o_read_value;
    logic [STATUS_W-1:0]       o_status;
    logic [COUNT_W-1:0]        o_entry_count;

    deque_req_t                pending_requests[$];
    deque_req_t                next_req;
    deque_result_t             expected_results[$];
    deque_result_t             oldest_result;
    logic signed [VALUE_W-1:0] held_words[$];
    int unsigned               mismatch_count = 0;
    int unsigned               quiet_cycles = 0;

    deque_with_delete_by_value u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .busy          (busy),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Applies one accepted request to the deque image and queues the result it must give.
    function automatic void predict_deque_op(input logic [OP_W-1:0] op,
                                             input logic signed [VALUE_W-1:0] word);
        deque_result_t res;
        int            hit;
        res.read_value = '0;
        res.status     = ST_OK;
        hit            = -1;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (held_words.size() >= DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else if (op == OP_PUSH_BACK) begin
                    held_words.push_back(word);
                end else begin
                    held_words.push_front(word);
                end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
                if (held_words.size() == 0) begin
                    res.status = ST_EMPTY;
                end else if (op == OP_POP_BACK) begin
                    res.read_value = held_words.pop_back();
                end else begin
                    res.read_value = held_words.pop_front();
                end
            end
            OP_DELETE: begin
                if (held_words.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (int k = held_words.size() - 1; k >= 0; k--) begin
                        if (held_words[k] == word) hit = k;
                    end
                    if (hit < 0) begin
                        res.status = ST_NO_MATCH;
                    end else begin
                        held_words.delete(hit);
                    end
                end
            end
            default: begin
            end
        endcase
        res.entry_count = COUNT_W'(held_words.size());
        expected_results.push_back(res);
    endfunction

    function automatic void queue_request(input logic [OP_W-1:0] op,
                                          input logic signed [VALUE_W-1:0] value,
                                          input int unsigned idle_pct);
        deque_req_t req;
        req.op       = op;
        req.value    = value;
        req.idle_pct = idle_pct;
        pending_requests.push_back(req);
    endfunction

    // Mostly a small pool of words so that deletes find matches and duplicates occur.
    function automatic logic signed [VALUE_W-1:0] pick_word();
        if ($urandom_range(0, 99) >= 70) return $urandom();
        case ($urandom_range(0, 5))
            0: return 32'sh0000_0000;
            1: return 32'sh0000_0001;
            2: return 32'shFFFF_FFFF;
            3: return 32'sh8000_0000;
            4: return 32'sh7FFF_FFFF;
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    // A run either fills, drains or mixes, so the deque reaches both full and empty.
    function automatic logic [OP_W-1:0] pick_op(input int unsigned run_kind);
        int unsigned roll;
        int unsigned push_lim;
        int unsigned pop_lim;
        roll = $urandom_range(0, 99);
        case (run_kind)
            0:       begin push_lim = 70; pop_lim = 82; end
            1:       begin push_lim = 12; pop_lim = 82; end
            default: begin push_lim = 30; pop_lim = 60; end
        endcase
        if (roll < push_lim) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (roll < pop_lim) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        if (roll < 96) return OP_DELETE;
        return OP_DELETE + OP_W'($urandom_range(1, 3));
    endfunction

    initial begin
        int unsigned phase_idle[4];
        int unsigned run_kind;
        int unsigned run_left;
        phase_idle[0] = 0;
        phase_idle[1] = 83;
        phase_idle[2] = 0;
        phase_idle[3] = 35;

        // Empty-deque cases, then the word extremes, duplicates and the unused codes.
        queue_request(OP_POP_BACK, 32'sh0, 0);
        queue_request(OP_POP_FRONT, 32'shFFFF_FFFF, 0);
        queue_request(OP_DELETE, 32'sh5, 0);
        queue_request(OP_PUSH_BACK, 32'sh7FFF_FFFF, 0);
        queue_request(OP_PUSH_FRONT, 32'sh8000_0000, 0);
        queue_request(OP_PUSH_BACK, 32'sh0, 0);
        queue_request(OP_PUSH_BACK, 32'shFFFF_FFFF, 0);
        queue_request(OP_PUSH_FRONT, 32'sh1, 0);
        queue_request(OP_PUSH_BACK, 32'sh0, 0);
        queue_request(OP_DELETE + OP_W'(1), 32'sh7FFF_FFFF, 0);
        queue_request(OP_DELETE + OP_W'(2), 32'sh8000_0000, 0);
        queue_request(OP_DELETE + OP_W'(3), 32'shFFFF_FFFF, 0);
        queue_request(OP_DELETE, 32'sh0, 0);
        queue_request(OP_DELETE, 32'sh3039, 0);
        queue_request(OP_DELETE, 32'sh1, 0);
        queue_request(OP_DELETE, 32'sh0, 0);
        queue_request(OP_POP_BACK, 32'sh7FFF_FFFF, 0);
        queue_request(OP_POP_FRONT, 32'sh8000_0000, 0);
        queue_request(OP_DELETE, 32'sh7FFF_FFFF, 0);
        queue_request(OP_DELETE, 32'sh7FFF_FFFF, 0);

        for (int p = 0; p < 4; p++) begin
            run_left = 0;
            run_kind = 0;
            for (int n = 0; n < ITEMS_PER_RUN; n++) begin
                if (run_left == 0) begin
                    run_kind = $urandom_range(0, 2);
                    run_left = $urandom_range(5, 40);
                end
                run_left--;
                queue_request(pick_op(run_kind), pick_word(), phase_idle[p]);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || start) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // A request is taken at an edge where start is high and busy is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) predict_deque_op(i_operation, i_value);
            if (pending_requests.size() != 0 &&
                $urandom_range(0, 99) >= pending_requests[0].idle_pct) begin
                next_req = pending_requests.pop_front();
                start       <= 1'b1;
                i_operation <= next_req.op;
                i_value     <= next_req.value;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: read_value %0d status %0d entry_count %0d",
                       o_read_value, o_status, o_entry_count);
                mismatch_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (o_read_value !== oldest_result.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           oldest_result.read_value, o_read_value);
                    mismatch_count++;
                end
                if (o_status !== oldest_result.status) begin
                    $error("status: expected %0d, got %0d", oldest_result.status, o_status);
                    mismatch_count++;
                end
                if (o_entry_count !== oldest_result.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           oldest_result.entry_count, o_entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends a hung run: counts edges with neither a request taken nor a result shown.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

// ===== files.f =====
sv/dqdel_pkg.sv
sv/deque_with_delete_by_value.sv
sim/tb_top.sv
